[sv/nmea_sentence_field_splitter_assert.svh]
// Assertion macros shared by the checker of the NMEA sentence field splitter.
// No dependencies; included by the files that assert.
`ifndef NMEA_SENTENCE_FIELD_SPLITTER_ASSERT_SVH
`define NMEA_SENTENCE_FIELD_SPLITTER_ASSERT_SVH

// Clocked assertion that is switched off while reset is high.
`define NSFS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define NSFS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/nmea_sfs_pkg.sv]
// Package of the NMEA sentence field splitter: result codes, header table,
// parser phases and the structs passed between parser and result queue.
// No dependencies.
`default_nettype none

package nmea_sfs_pkg;

  // Result kinds
  localparam logic [1:0] KIND_FIELD_BYTE = 2'd0;
  localparam logic [1:0] KIND_FIELD_END  = 2'd1;
  localparam logic [1:0] KIND_PREFIX     = 2'd2;
  localparam logic [1:0] KIND_SENT_END   = 2'd3;

  // Sentence types
  localparam logic [2:0] TYPE_UNKNOWN = 3'd0;
  localparam logic [2:0] TYPE_HDT     = 3'd1;
  localparam logic [2:0] TYPE_CCD     = 3'd2;
  localparam logic [2:0] TYPE_HDG     = 3'd3;
  localparam logic [2:0] TYPE_HPR     = 3'd4;
  localparam logic [2:0] TYPE_RCD     = 3'd5;

  // Special characters
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;

  // Known header names; character i sits at bits [8*i +: 8], so the
  // strings are written reversed. Entry t maps to sentence type t+1.
  localparam int NUM_HDR = 5;
  localparam logic [63:0] HDR_NAME [NUM_HDR] = '{
    64'("TDHCH"),   // HCHDT
    64'("DCCTNTP"), // PTNTCCD
    64'("GDHCH"),   // HCHDG
    64'("RPHTNTP"), // PTNTHPR
    64'("DCRTNTP")  // PTNTRCD
  };
  localparam int HDR_LEN [NUM_HDR] = '{5, 7, 5, 7, 7};

  // Depth of the result queue
  localparam int QDEPTH = 4;

  typedef enum logic [1:0] {
    PH_WAIT,
    PH_HEAD,
    PH_FIELDS,
    PH_TRAIL
  } phase_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] stype;
    logic [3:0] fnum;
    logic [7:0] data;
    logic [7:0] xsum;
    logic       last;
  } res_t;

  // Results produced by one byte: count, then up to two entries in order
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

  // Number of data fields emitted per sentence type
  function automatic logic [3:0] type_limit(logic [2:0] t);
    logic [3:0] lim;
    unique case (t)
      TYPE_HDT: lim = 4'd2;
      TYPE_CCD: lim = 4'd8;
      TYPE_HDG: lim = 4'd5;
      TYPE_HPR: lim = 4'd7;
      TYPE_RCD: lim = 4'd7;
      default:  lim = 4'd0;
    endcase
    return lim;
  endfunction

endpackage

`default_nettype wire

[sv/nmea_sfs_parser.sv]
// Parser of the NMEA sentence field splitter: input word register, sentence
// state and the logic that turns one byte into up to two results.
// Depends on nmea_sfs_pkg.
`default_nettype none

module nmea_sfs_parser
  import nmea_sfs_pkg::*;
#(
  parameter int HEADER_CHARS = 7
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_ready,
  input  logic [7:0] byte_in,
  input  logic       room,
  output push_t      push
);

  localparam int HCW = $clog2(HEADER_CHARS + 1);
  localparam int HIW = $clog2(HEADER_CHARS);

  // Input word register
  logic       in_full;
  logic [7:0] in_byte;
  logic       proc;

  // Sentence state
  phase_t     phase, phase_next;
  logic [7:0] hdr [HEADER_CHARS];
  logic [HCW-1:0] hdr_count, hdr_count_next;
  logic       hdr_over, hdr_over_next;
  logic       hdr_wr;
  logic [2:0] cur_type, cur_type_next;
  logic [3:0] fcount, fcount_next;
  logic [7:0] rxor, rxor_next;

  logic [2:0] match_type;
  logic       hit;
  logic       is_lf, is_sep, is_end, open;

  assign proc       = in_full && room;
  assign byte_ready = !in_full || proc;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (byte_ready) begin
      in_full <= byte_valid;
    end
    if (byte_ready && byte_valid) begin
      in_byte <= byte_in;
    end
  end

  // Header match against the known names
  always_comb begin
    match_type = TYPE_UNKNOWN;
    for (int t = NUM_HDR - 1; t >= 0; t--) begin
      hit = !hdr_over && (HDR_LEN[t] <= HEADER_CHARS) &&
            (hdr_count == HCW'(HDR_LEN[t]));
      for (int i = 0; i < HEADER_CHARS; i++) begin
        if (i < HDR_LEN[t] && hdr[i] != HDR_NAME[t][8*i +: 8]) begin
          hit = 1'b0;
        end
      end
      if (hit) begin
        match_type = 3'(t + 1);
      end
    end
  end

  assign is_lf  = (in_byte == CH_LF);
  assign is_end = (in_byte == CH_STAR) || (in_byte == CH_CR);
  assign is_sep = (in_byte == CH_COMMA) || is_end;
  assign open   = fcount < type_limit(cur_type);

  // Next state
  always_comb begin
    phase_next     = phase;
    hdr_count_next = hdr_count;
    hdr_over_next  = hdr_over;
    cur_type_next  = cur_type;
    fcount_next    = fcount;
    rxor_next      = rxor;
    hdr_wr         = 1'b0;
    if (proc) begin
      if (is_lf) begin
        phase_next     = PH_WAIT;
        hdr_count_next = '0;
        hdr_over_next  = 1'b0;
        cur_type_next  = TYPE_UNKNOWN;
        fcount_next    = '0;
        rxor_next      = '0;
      end else begin
        unique case (phase)
          PH_WAIT: begin
            if (in_byte == CH_DOLLAR) begin
              phase_next     = PH_HEAD;
              hdr_count_next = '0;
              hdr_over_next  = 1'b0;
              cur_type_next  = TYPE_UNKNOWN;
              fcount_next    = '0;
              rxor_next      = '0;
            end
          end
          PH_HEAD: begin
            if (in_byte == CH_COMMA) begin
              rxor_next     = rxor ^ in_byte;
              cur_type_next = match_type;
              fcount_next   = '0;
              phase_next    = PH_FIELDS;
            end else if (is_end) begin
              cur_type_next = TYPE_UNKNOWN;
              phase_next    = PH_TRAIL;
            end else begin
              rxor_next = rxor ^ in_byte;
              if (hdr_count < HCW'(HEADER_CHARS)) begin
                hdr_wr         = 1'b1;
                hdr_count_next = hdr_count + 1'b1;
              end else begin
                hdr_over_next = 1'b1;
              end
            end
          end
          PH_FIELDS: begin
            if (in_byte == CH_COMMA) begin
              rxor_next = rxor ^ in_byte;
              if (fcount != 4'd15) begin
                fcount_next = fcount + 1'b1;
              end
            end else if (is_end) begin
              phase_next = PH_TRAIL;
            end else begin
              rxor_next = rxor ^ in_byte;
            end
          end
          PH_TRAIL: begin
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Results
  always_comb begin
    push = '0;
    if (proc) begin
      if (is_lf) begin
        if (phase == PH_FIELDS && open) begin
          push.n  = 2'd2;
          push.r0 = '{KIND_FIELD_END, cur_type, fcount, 8'd0, 8'd0, 1'b0};
          push.r1 = '{KIND_SENT_END, cur_type, fcount, 8'd0, rxor, 1'b1};
        end else begin
          push.n  = 2'd1;
          push.r0 = '{KIND_SENT_END, cur_type, fcount, 8'd0, rxor, 1'b1};
        end
      end else begin
        unique case (phase)
          PH_WAIT: begin
            if (in_byte != CH_DOLLAR) begin
              push.n  = 2'd1;
              push.r0 = '{KIND_PREFIX, TYPE_UNKNOWN, 4'd0, in_byte, 8'd0, 1'b1};
            end
          end
          PH_FIELDS: begin
            if (open) begin
              push.n = 2'd1;
              if (is_sep) begin
                push.r0 = '{KIND_FIELD_END, cur_type, fcount, 8'd0, 8'd0, 1'b1};
              end else begin
                push.r0 = '{KIND_FIELD_BYTE, cur_type, fcount, in_byte, 8'd0, 1'b1};
              end
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_WAIT;
      hdr_count <= '0;
      hdr_over  <= 1'b0;
      cur_type  <= TYPE_UNKNOWN;
      fcount    <= '0;
      rxor      <= '0;
    end else begin
      phase     <= phase_next;
      hdr_count <= hdr_count_next;
      hdr_over  <= hdr_over_next;
      cur_type  <= cur_type_next;
      fcount    <= fcount_next;
      rxor      <= rxor_next;
    end
    // header characters past the count are never compared, so no reset
    if (hdr_wr) begin
      hdr[hdr_count[HIW-1:0]] <= in_byte;
    end
  end

endmodule

`default_nettype wire

[sv/nmea_sfs_outq.sv]
// Result queue of the NMEA sentence field splitter: a small register queue
// that takes up to two results per cycle and hands out one.
// Depends on nmea_sfs_pkg.
`default_nettype none

module nmea_sfs_outq
  import nmea_sfs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  push_t      push,
  output logic       room,
  output logic       res_valid,
  input  logic       res_ready,
  output res_t       res
);

  localparam int PW = $clog2(QDEPTH);
  localparam int CW = $clog2(QDEPTH + 1);

  res_t          q [QDEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          pop;

  // room for a two-result word without looking at this cycle's pop
  assign room      = count <= CW'(QDEPTH - 2);
  assign res_valid = count != '0;
  assign pop       = res_valid && res_ready;
  assign res       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PW'(push.n);
      rd_ptr <= rd_ptr + PW'(pop);
      count  <= count + CW'(push.n) - CW'(pop);
    end
    if (push.n != 2'd0) begin
      q[wr_ptr] <= push.r0;
    end
    if (push.n == 2'd2) begin
      q[wr_ptr + 1'b1] <= push.r1;
    end
  end

endmodule

`default_nettype wire

[sv/nmea_sentence_field_splitter.sv]
// Top level of the NMEA sentence field splitter: parser and result queue.
// Depends on nmea_sfs_pkg, nmea_sfs_parser and nmea_sfs_outq.
//
//   channel  handshake              payload
//   byte     byte_valid/byte_ready  byte_in
//   result   res_valid/res_ready    kind, sentence_type, field_number,
//                                   data_byte, xor_sum, last
//
// One byte is taken per cycle while the result queue has room; its results pass through
// the input word register and the four-entry result queue.
// A line feed that closes an open field gives two results, so the result
// port sets the rate at one result per cycle.
// With fewer than two free queue entries the input register stalls, then byte_ready.
// rst is synchronous and clears the parser state and the queue.
`default_nettype none

module nmea_sentence_field_splitter
  import nmea_sfs_pkg::*;
#(
  parameter int HEADER_CHARS = 7
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_ready,
  input  logic [7:0] byte_in,
  output logic       res_valid,
  input  logic       res_ready,
  output logic [1:0] kind,
  output logic [2:0] sentence_type,
  output logic [3:0] field_number,
  output logic [7:0] data_byte,
  output logic [7:0] xor_sum,
  output logic       last
);

  push_t push;
  logic  room;
  res_t  res;

  nmea_sfs_parser #(
    .HEADER_CHARS(HEADER_CHARS)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .byte_valid(byte_valid),
    .byte_ready(byte_ready),
    .byte_in   (byte_in),
    .room      (room),
    .push      (push)
  );

  nmea_sfs_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .room     (room),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  assign kind          = res.kind;
  assign sentence_type = res.stype;
  assign field_number  = res.fnum;
  assign data_byte     = res.data;
  assign xor_sum       = res.xsum;
  assign last          = res.last;

endmodule

`default_nettype wire

[sv/nmea_sfs_checker.sv]
// Port checker of the NMEA sentence field splitter, bound to the top level.
// Depends on nmea_sfs_pkg and nmea_sentence_field_splitter_assert.svh.
`default_nettype none
`include "nmea_sentence_field_splitter_assert.svh"

module nmea_sfs_checker
  import nmea_sfs_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       res_valid,
  input logic       res_ready,
  input logic [1:0] kind,
  input logic [2:0] sentence_type,
  input logic [3:0] field_number,
  input logic [7:0] data_byte,
  input logic [7:0] xor_sum,
  input logic       last
);

  logic        is_prefix, prefix_ok;
  logic        is_field, field_ok;
  logic        res_stall;
  logic [25:0] res_word;

  assign is_prefix = res_valid && (kind == KIND_PREFIX);
  assign prefix_ok = (sentence_type == TYPE_UNKNOWN) && (field_number == 4'd0) &&
                     (xor_sum == 8'd0) && last;
  assign is_field  = res_valid && (kind == KIND_FIELD_BYTE || kind == KIND_FIELD_END);
  assign field_ok  = (sentence_type != TYPE_UNKNOWN) && (xor_sum == 8'd0) &&
                     (kind == KIND_FIELD_END || last);
  assign res_stall = res_valid && !res_ready;
  assign res_word  = {kind, sentence_type, field_number, data_byte, xor_sum, last};

  // reset empties the result queue
  `NSFS_ASSERT_ALWAYS(a_rst_empty, rst |=> !res_valid, "result valid after reset")

  // a prefix word carries no sentence information
  `NSFS_ASSERT(a_prefix_clean, is_prefix |-> prefix_ok, "bad prefix word")

  // field words exist only for known types; a field byte always ends its input word
  `NSFS_ASSERT(a_field_known, is_field |-> field_ok, "bad field word")

  // a stalled result holds
  `NSFS_ASSERT(a_res_hold, res_stall |=> (res_valid && $stable(res_word)), "stalled result changed")

endmodule

bind nmea_sentence_field_splitter nmea_sfs_checker u_nmea_sfs_checker (.*);

`default_nettype wire
